@@ rtl/core/etbq_pkg.sv @@
package etbq_pkg;

   // default geometry
   localparam int DEF_BATCHES   = 2;
   localparam int DEF_HEIGHT    = 64;
   localparam int DEF_WIDTH     = 64;
   localparam int DEF_QUEUE_LEN = 8;

   // field widths
   localparam int VAL_W      = 24;
   localparam int BIN_W      = 13;
   localparam int IDX_W      = 12;
   localparam int TIME_W     = 32;
   localparam int PIX_W      = 6;
   localparam int SLOT_W     = 6;
   localparam int BWID_W     = 24;
   localparam int FRAC_BITS  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START0    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START1    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH = 2'd2;

   localparam logic [BWID_W-1:0] BIN_WIDTH_RESET = 24'd1000;

   localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;
   localparam logic signed [VAL_W-1:0] ONE_FX  = 24'sd256;
   localparam logic signed [BIN_W-1:0] NO_BIN  = -13'sd1;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic signed [BIN_W-1:0] bin;
   } hist_entry_type;

   // saturate a widened sum to the value range
   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W+1:0] v);
      logic signed [VAL_W+1:0] hi;
      logic signed [VAL_W+1:0] lo;
      hi = {2'b00, VAL_MAX};
      lo = {2'b11, VAL_MIN};
      if (v > hi) begin
         return VAL_MAX;
      end else if (v < lo) begin
         return VAL_MIN;
      end
      return v[VAL_W-1:0];
   endfunction

endpackage

@@ rtl/core/etbq_req_if.sv @@
interface etbq_req_if import etbq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic               batch;
   logic [PIX_W-1:0]   pixel_x;
   logic [PIX_W-1:0]   pixel_y;
   logic               polarity;
   logic [IDX_W-1:0]   bin_index;
   logic [TIME_W-1:0]  event_time;

   modport source (output valid, mode, batch, pixel_x, pixel_y, polarity, bin_index,
                   event_time, input ready);
   modport sink (input valid, mode, batch, pixel_x, pixel_y, polarity, bin_index,
                 event_time, output ready);
endinterface

@@ rtl/core/etbq_rsp_if.sv @@
interface etbq_rsp_if import etbq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [VAL_W-1:0]  slot_value;
   logic signed [BIN_W-1:0]  slot_bin;
   logic [SLOT_W-1:0]        slot_index;
   logic                     last_slot;

   modport source (output valid, slot_value, slot_bin, slot_index, last_slot, input ready);
   modport sink (input valid, slot_value, slot_bin, slot_index, last_slot, output ready);
endinterface

@@ rtl/core/event_time_bin_queue_top.sv @@
// channel  | dir | handshake           | payload
// req_ch   | in  | valid/ready         | mode, batch, pixel_x, pixel_y, polarity,
//          |     |                     | bin_index, event_time
// rsp_ch   | out | valid/ready         | slot_value, slot_bin, slot_index, last_slot
// csr_*    | in  | csr_we (no stall)   | csr_index, csr_wdata
//
// One transaction in flight at a time; req_ch.ready is high only when idle.
// Accumulate transaction: LOAD, NUM, MAG, the 23-step restoring divider (DIV), UPD.
// Readout transaction: LOAD, FLUSH, then RD_ISSUE, RD_WAIT and OUT for each slot, where OUT
// waits out any rsp_ch stall; each slot takes one history memory read.
// After reset a clearing pass writes every one of the 2*BATCHES*HEIGHT*WIDTH cell entries
// (16384 at defaults); csr writes are taken during it.
// Reset is synchronous, active high; history memory is not cleared.
module event_time_bin_queue_top import etbq_pkg::*; #(
   parameter int BATCHES   = DEF_BATCHES,
   parameter int HEIGHT    = DEF_HEIGHT,
   parameter int WIDTH     = DEF_WIDTH,
   parameter int QUEUE_LEN = DEF_QUEUE_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   etbq_req_if.sink              req_ch,
   etbq_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CELLS      = 2 * BATCHES * HEIGHT * WIDTH;
   localparam int CELL_W     = $clog2(CELLS);
   localparam int HEAD_W     = (QUEUE_LEN > 1) ? $clog2(QUEUE_LEN) : 1;
   localparam int CNT_W      = $clog2(QUEUE_LEN + 1);
   localparam int HIST_DEPTH = CELLS * QUEUE_LEN;
   localparam int HIST_W     = $clog2(HIST_DEPTH);
   localparam int PROD_W     = BWID_W + IDX_W;
   localparam int NUM_W      = PROD_W + 2;
   localparam int MAG_W      = NUM_W - 1;
   localparam int DIV_STEPS  = VAL_W - 1;
   localparam int SHIFT      = DIV_STEPS - FRAC_BITS;
   localparam int REM_W      = BWID_W + 1;
   localparam int DCNT_W     = $clog2(DIV_STEPS);

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic signed [BIN_W-1:0] bin;
      logic [HEAD_W-1:0]       head;
      logic [CNT_W-1:0]        count;
   } cell_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOAD, S_NUM, S_MAG, S_DIV, S_UPD,
      S_FLUSH, S_RD_ISSUE, S_RD_WAIT, S_OUT
   } state_type;

   localparam cell_type CELL_RESET = '{value: '0, bin: NO_BIN, head: '0, count: '0};

   // configuration registers
   logic [TIME_W-1:0] start0_ff, start1_ff;
   logic [BWID_W-1:0] bin_width_ff;
   logic [BWID_W-1:0] w_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start0_ff    <= '0;
         start1_ff    <= '0;
         bin_width_ff <= BIN_WIDTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START0:    start0_ff    <= csr_wdata[TIME_W-1:0];
            CSR_START1:    start1_ff    <= csr_wdata[TIME_W-1:0];
            CSR_BIN_WIDTH: bin_width_ff <= csr_wdata[BWID_W-1:0];
            default: ;
         endcase
      end
   end

   // zero width behaves as one
   assign w_eff = (bin_width_ff == '0) ? BWID_W'(1) : bin_width_ff;

   state_type               state_ff;
   logic [CELL_W-1:0]       clr_ff;
   logic [CELL_W-1:0]       cell_ff;
   logic                    mode_ff;
   logic                    batch_ff;
   logic [IDX_W-1:0]        z_ff;
   logic [TIME_W-1:0]       t_ff;
   logic signed [VAL_W-1:0] cur_val_ff;
   logic signed [BIN_W-1:0] cur_bin_ff;
   logic [HEAD_W-1:0]       cur_head_ff;
   logic [CNT_W-1:0]        cur_cnt_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic                    neg_ff;
   logic                    sat_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [DIV_STEPS-1:0]    lo_ff;
   logic [DIV_STEPS-1:0]    q_ff;
   logic [DCNT_W-1:0]       dcnt_ff;
   logic [SLOT_W-1:0]       k_ff;
   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic signed [BIN_W-1:0] rsp_bin_ff;

   // memories
   cell_type       cell_mem [CELLS];
   hist_entry_type hist_mem [HIST_DEPTH];
   cell_type       cell_q;
   hist_entry_type hist_q;

   logic              cell_we, cell_re;
   logic [CELL_W-1:0] cell_wa, cell_ra;
   cell_type          cell_wd;
   logic              hist_we, hist_re;
   logic [HIST_W-1:0] hist_wa, hist_ra;
   hist_entry_type    hist_wd;

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= cell_wd;
      end
      if (cell_re) begin
         cell_q <= cell_mem[cell_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      if (hist_re) begin
         hist_q <= hist_mem[hist_ra];
      end
   end

   // request decode
   logic              req_fire;
   logic              in_range;
   logic [CELL_W-1:0] req_cell;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_range     = (int'(req_ch.batch) < BATCHES) && (int'(req_ch.pixel_x) < WIDTH) &&
                         (int'(req_ch.pixel_y) < HEIGHT);
   assign req_cell     = CELL_W'(int'(req_ch.polarity) * BATCHES * HEIGHT * WIDTH +
                                 int'(req_ch.batch) * HEIGHT * WIDTH +
                                 int'(req_ch.pixel_y) * WIDTH + int'(req_ch.pixel_x));

   // shared per-cell arithmetic
   logic                    push;
   logic [HEAD_W-1:0]       head_next;
   logic [CNT_W-1:0]        cnt_next;
   logic signed [BIN_W-1:0] z_bin;
   logic [MAG_W-1:0]        mag;
   logic [REM_W-1:0]        rem_sh;
   logic                    rem_ge;

   assign z_bin     = $signed({1'b0, z_ff});
   assign push      = (cur_bin_ff >= 0) && (z_bin > cur_bin_ff);
   assign head_next = (cur_head_ff == HEAD_W'(QUEUE_LEN - 1)) ? '0 : cur_head_ff + 1'b1;
   assign cnt_next  = (cur_cnt_ff == CNT_W'(QUEUE_LEN)) ? cur_cnt_ff : cur_cnt_ff + 1'b1;
   assign mag       = num_ff[NUM_W-1] ? MAG_W'(-num_ff) : MAG_W'(num_ff);
   assign rem_sh    = {rem_ff[REM_W-2:0], lo_ff[DIV_STEPS-1]};
   assign rem_ge    = rem_sh >= {1'b0, w_eff};

   // accumulate update
   logic signed [VAL_W-1:0] frac;
   logic signed [VAL_W-1:0] base_val;
   logic signed [VAL_W-1:0] new_open;
   logic signed [VAL_W-1:0] nv;
   logic signed [BIN_W-1:0] nb;
   logic                    n_valid;
   logic                    adj;
   logic signed [VAL_W-1:0] adj_val;

   always_comb begin
      if (sat_ff) begin
         frac = neg_ff ? VAL_MIN : VAL_MAX;
      end else if (neg_ff) begin
         frac = -$signed({1'b0, q_ff});
      end else begin
         frac = $signed({1'b0, q_ff});
      end
      base_val = push ? '0 : cur_val_ff;
      new_open = sat_val({{2{base_val[VAL_W-1]}}, base_val} + {{2{frac[VAL_W-1]}}, frac});
      nv       = push ? cur_val_ff : hist_q.value;
      nb       = push ? cur_bin_ff : hist_q.bin;
      n_valid  = push || (cur_cnt_ff != '0);
      adj      = n_valid && ((nb + 13'sd1) == z_bin);
      adj_val  = sat_val({{2{nv[VAL_W-1]}}, nv} + {{2{ONE_FX[VAL_W-1]}}, ONE_FX} -
                         {{2{frac[VAL_W-1]}}, frac});
   end

   // readout slot location
   logic              slot_present;
   logic [HEAD_W-1:0] slot_idx;

   always_comb begin
      int age;
      int h;
      age = QUEUE_LEN - 1 - int'(k_ff);
      h   = int'(cur_head_ff) - age;
      if (h < 0) begin
         h = h + QUEUE_LEN;
      end
      slot_present = age < int'(cur_cnt_ff);
      slot_idx     = HEAD_W'(h);
   end

   // memory port control
   always_comb begin
      cell_we = 1'b0;
      cell_wa = cell_ff;
      cell_wd = CELL_RESET;
      cell_re = req_fire;
      cell_ra = req_cell;
      hist_we = 1'b0;
      hist_wa = HIST_W'(int'(cell_ff) * QUEUE_LEN + int'(head_next));
      hist_wd = '{value: cur_val_ff, bin: cur_bin_ff};
      hist_re = 1'b0;
      hist_ra = HIST_W'(int'(cell_ff) * QUEUE_LEN + int'(cur_head_ff));
      case (state_ff)
         S_CLEAR: begin
            cell_we = 1'b1;
            cell_wa = clr_ff;
         end
         S_MAG: begin
            hist_re = 1'b1;
         end
         S_UPD: begin
            cell_we = 1'b1;
            cell_wd = '{value: new_open,
                        bin:   ((cur_bin_ff < 0) || push) ? z_bin : cur_bin_ff,
                        head:  push ? head_next : cur_head_ff,
                        count: push ? cnt_next : cur_cnt_ff};
            if (push) begin
               hist_we = 1'b1;
               hist_wd = '{value: adj ? adj_val : nv, bin: nb};
            end else if (adj) begin
               hist_we = 1'b1;
               hist_wa = HIST_W'(int'(cell_ff) * QUEUE_LEN + int'(cur_head_ff));
               hist_wd = '{value: adj_val, bin: nb};
            end
         end
         S_FLUSH: begin
            hist_we = (cur_val_ff > 0);
         end
         S_RD_ISSUE: begin
            hist_re = 1'b1;
            hist_ra = HIST_W'(int'(cell_ff) * QUEUE_LEN + int'(slot_idx));
         end
         S_OUT: begin
            cell_we = rsp_ch.ready && (k_ff == SLOT_W'(QUEUE_LEN - 1));
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               if (clr_ff == CELL_W'(CELLS - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  clr_ff <= clr_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_fire && in_range) begin
                  cell_ff  <= req_cell;
                  mode_ff  <= req_ch.mode;
                  batch_ff <= req_ch.batch;
                  z_ff     <= req_ch.bin_index;
                  t_ff     <= req_ch.event_time;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               cur_val_ff  <= cell_q.value;
               cur_bin_ff  <= cell_q.bin;
               cur_head_ff <= cell_q.head;
               cur_cnt_ff  <= cell_q.count;
               prod_ff     <= w_eff * z_ff;
               k_ff        <= '0;
               state_ff    <= mode_ff ? S_FLUSH : S_NUM;
            end
            S_NUM: begin
               num_ff <= $signed({{(NUM_W-TIME_W){1'b0}}, t_ff}) -
                         $signed({{(NUM_W-TIME_W){1'b0}}, batch_ff ? start1_ff : start0_ff}) -
                         $signed({2'b00, prod_ff});
               state_ff <= S_MAG;
            end
            S_MAG: begin
               neg_ff   <= num_ff[NUM_W-1];
               // quotient would reach 2^23: saturates either way
               sat_ff   <= {2'b00, mag} >= {w_eff, {SHIFT{1'b0}}};
               rem_ff   <= REM_W'(mag >> SHIFT);
               lo_ff    <= {mag[SHIFT-1:0], {FRAC_BITS{1'b0}}};
               q_ff     <= '0;
               dcnt_ff  <= DCNT_W'(DIV_STEPS - 1);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff <= rem_ge ? rem_sh - {1'b0, w_eff} : rem_sh;
               q_ff   <= {q_ff[DIV_STEPS-2:0], rem_ge};
               lo_ff  <= lo_ff << 1;
               dcnt_ff <= dcnt_ff - 1'b1;
               if (dcnt_ff == '0) begin
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               state_ff <= S_IDLE;
            end
            S_FLUSH: begin
               // positive open bin moves into the history first
               if (cur_val_ff > 0) begin
                  cur_head_ff <= head_next;
                  cur_cnt_ff  <= cnt_next;
               end
               state_ff <= S_RD_ISSUE;
            end
            S_RD_ISSUE: begin
               state_ff <= S_RD_WAIT;
            end
            S_RD_WAIT: begin
               rsp_value_ff <= slot_present ? hist_q.value : '0;
               rsp_bin_ff   <= slot_present ? hist_q.bin : NO_BIN;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (k_ff == SLOT_W'(QUEUE_LEN - 1)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_RD_ISSUE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.slot_value = rsp_value_ff;
   assign rsp_ch.slot_bin   = rsp_bin_ff;
   assign rsp_ch.slot_index = k_ff;
   assign rsp_ch.last_slot  = (k_ff == SLOT_W'(QUEUE_LEN - 1));

   // restoring divider keeps its remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !sat_ff) |-> (rem_ff < {1'b0, w_eff}))
      else $error("divider remainder out of range");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD || state_ff == S_RD_ISSUE) |-> (int'(cur_cnt_ff) <= QUEUE_LEN))
      else $error("history count above queue length");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD || state_ff == S_RD_ISSUE) |-> (int'(cur_head_ff) < QUEUE_LEN))
      else $error("history head out of range");

   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (state_ff == S_OUT && !req_ch.ready))
      else $error("response outside readout");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import etbq_pkg::*;

   localparam int QLEN   = DEF_QUEUE_LEN;
   localparam int CELLS  = 2 * DEF_BATCHES * DEF_HEIGHT * DEF_WIDTH;
   localparam int LIMIT  = 600000;
   localparam int SETTLE = 40;           // longer than an accumulate transaction
   localparam logic MODE_ACC  = 1'b0;
   localparam logic MODE_READ = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // no register behind it

   typedef enum int {IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE} idle_mode_type;

   typedef struct {
      logic                     mode;
      logic                     batch;
      logic [PIX_W-1:0]         px;
      logic [PIX_W-1:0]         py;
      logic                     pol;
      logic [IDX_W-1:0]         bin;
      logic [TIME_W-1:0]        t;
      bit                       typed;     // expectation written by hand below
      logic signed [VAL_W-1:0]  newest_val;
      logic signed [BIN_W-1:0]  newest_bin;
   } event_row_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic signed [BIN_W-1:0] bin;
      logic [SLOT_W-1:0]       index;
      logic                    last;
   } slot_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   etbq_req_if req_ch ();
   etbq_rsp_if rsp_ch ();

   event_time_bin_queue_top uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // shadow copy of the block's registers and per-cell state
   logic [TIME_W-1:0] win_start [2];
   logic [BWID_W-1:0] bin_w;
   logic signed [VAL_W-1:0] open_val [CELLS];
   logic signed [BIN_W-1:0] open_bin [CELLS];
   logic signed [VAL_W-1:0] hist_val [CELLS*QLEN];
   logic signed [BIN_W-1:0] hist_bin [CELLS*QLEN];
   int unsigned hist_head [CELLS];
   int unsigned hist_cnt  [CELLS];

   slot_type   pending_slots [$];
   int         errors = 0;
   int         mismatches = 0;
   int         send_idle = 0;      // percent of transactions before which the sender sits out
   int         recv_idle = 0;      // percent of cycles the receiver stalls
   bit         hold_start = 1'b0;
   int         hold_left = 0;
   longint     cycles = 0;

   function automatic logic signed [VAL_W-1:0] clamp24(longint v);
      if (v > longint'(VAL_MAX)) return VAL_MAX;
      if (v < longint'(VAL_MIN)) return VAL_MIN;
      return v[VAL_W-1:0];
   endfunction

   function automatic void push_history(int c, logic signed [VAL_W-1:0] v,
                                        logic signed [BIN_W-1:0] b);
      hist_head[c] = (hist_head[c] + 1) % QLEN;
      hist_val[c*QLEN + hist_head[c]] = v;
      hist_bin[c*QLEN + hist_head[c]] = b;
      if (hist_cnt[c] < QLEN) hist_cnt[c]++;
   endfunction

   // advance the cell state by one transaction, append any readout slots
   function automatic void bin_queue_step(event_row_type r, ref slot_type slots[$]);
      int     c;
      longint w, num, mag, q;
      logic signed [VAL_W-1:0] frac;
      int     n, age;
      slot_type s;
      c = r.pol * 8192 + r.batch * 4096 + r.py * 64 + r.px;
      if (r.mode == MODE_ACC) begin
         w = (bin_w == 0) ? 1 : longint'(bin_w);
         num = longint'(r.t) - longint'(win_start[r.batch]) - w * longint'(r.bin);
         mag = (num < 0) ? -num : num;
         q = (mag << FRAC_BITS) / w;
         frac = clamp24((num < 0) ? -q : q);
         if (open_bin[c] < 0) begin
            open_bin[c] = $signed({1'b0, r.bin});
         end else if ($signed({1'b0, r.bin}) > open_bin[c]) begin
            push_history(c, open_val[c], open_bin[c]);
            open_val[c] = '0;
            open_bin[c] = $signed({1'b0, r.bin});
         end
         open_val[c] = clamp24(longint'(open_val[c]) + longint'(frac));
         if (hist_cnt[c] > 0) begin
            n = c*QLEN + hist_head[c];
            if (int'(hist_bin[n]) + 1 == int'(r.bin))
               hist_val[n] = clamp24(longint'(hist_val[n]) + 256 - longint'(frac));
         end
         return;
      end
      if (open_val[c] > 0) push_history(c, open_val[c], open_bin[c]);
      for (int k = 0; k < QLEN; k++) begin
         age = QLEN - 1 - k;
         s.value = '0;
         s.bin   = NO_BIN;
         if (age < hist_cnt[c]) begin
            n = c*QLEN + (hist_head[c] + QLEN - age) % QLEN;
            s.value = hist_val[n];
            s.bin   = hist_bin[n];
         end
         s.index = k[SLOT_W-1:0];
         s.last  = (k == QLEN - 1);
         slots.push_back(s);
      end
      open_val[c]  = '0;
      open_bin[c]  = NO_BIN;
      hist_head[c] = 0;
      hist_cnt[c]  = 0;
   endfunction

   // hand-written events and readouts; the typed readouts are of cells that hold at most one bin
   event_row_type directed_rows [] = '{
      // readout of an untouched cell: all slots empty
      '{MODE_READ, 1'b0, 6'd0,  6'd0,  1'b0, 12'd0,    32'd0,        1'b1, 24'sd0, -13'sd1},
      // latest time, highest bin, far corner: frac saturates high
      '{MODE_ACC,  1'b0, 6'd63, 6'd63, 1'b1, 12'd4095, 32'hFFFFFFFF, 1'b0, 24'sd0, -13'sd1},
      '{MODE_READ, 1'b0, 6'd63, 6'd63, 1'b1, 12'd0,    32'd0,        1'b1, VAL_MAX, 13'sd4095},
      // zero contribution: open bin is not positive, so dropped
      '{MODE_ACC,  1'b1, 6'd0,  6'd0,  1'b0, 12'd0,    32'd0,        1'b0, 24'sd0, -13'sd1},
      '{MODE_READ, 1'b1, 6'd0,  6'd0,  1'b0, 12'd0,    32'd0,        1'b1, 24'sd0, -13'sd1},
      // event before its own bin: negative value, dropped on readout
      '{MODE_ACC,  1'b1, 6'd5,  6'd2,  1'b0, 12'd5,    32'd0,        1'b0, 24'sd0, -13'sd1},
      '{MODE_READ, 1'b1, 6'd5,  6'd2,  1'b0, 12'd0,    32'd0,        1'b1, 24'sd0, -13'sd1},
      // two events in one bin, an adjacent newer bin, then an older event
      '{MODE_ACC,  1'b0, 6'd3,  6'd4,  1'b0, 12'd2,    32'd2500,     1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b0, 6'd3,  6'd4,  1'b0, 12'd2,    32'd2250,     1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b0, 6'd3,  6'd4,  1'b0, 12'd3,    32'd3250,     1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b0, 6'd3,  6'd4,  1'b0, 12'd1,    32'd1900,     1'b0, 24'sd0, -13'sd1},
      '{MODE_READ, 1'b0, 6'd3,  6'd4,  1'b0, 12'd0,    32'd0,        1'b0, 24'sd0, -13'sd1},
      // ten bins into one cell: history wraps and drops its oldest entries
      '{MODE_ACC,  1'b1, 6'd7,  6'd7,  1'b1, 12'd0,    32'd500,      1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b1, 6'd7,  6'd7,  1'b1, 12'd1,    32'd1500,     1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b1, 6'd7,  6'd7,  1'b1, 12'd2,    32'd2300,     1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b1, 6'd7,  6'd7,  1'b1, 12'd3,    32'd3900,     1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b1, 6'd7,  6'd7,  1'b1, 12'd4,    32'd4100,     1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b1, 6'd7,  6'd7,  1'b1, 12'd5,    32'd5500,     1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b1, 6'd7,  6'd7,  1'b1, 12'd6,    32'd6700,     1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b1, 6'd7,  6'd7,  1'b1, 12'd7,    32'd7050,     1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b1, 6'd7,  6'd7,  1'b1, 12'd8,    32'd8999,     1'b0, 24'sd0, -13'sd1},
      '{MODE_ACC,  1'b1, 6'd7,  6'd7,  1'b1, 12'd9,    32'd9400,     1'b0, 24'sd0, -13'sd1},
      '{MODE_READ, 1'b1, 6'd7,  6'd7,  1'b1, 12'd0,    32'd0,        1'b0, 24'sd0, -13'sd1}
   };

   // cycle counter / watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stalls, one long hold, compare against oldest expectation
   always @(posedge clock) begin
      slot_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_slots.size() == 0) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected slot %0d value %0d bin %0d", rsp_ch.slot_index,
                           rsp_ch.slot_value, rsp_ch.slot_bin);
            end else begin
               want = pending_slots[0];
               pending_slots.delete(0);
               if (rsp_ch.slot_value !== want.value || rsp_ch.slot_bin !== want.bin ||
                   rsp_ch.slot_index !== want.index || rsp_ch.last_slot !== want.last) begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("slot mismatch: exp v=%0d b=%0d i=%0d l=%0d got v=%0d b=%0d i=%0d l=%0d",
                              want.value, want.bin, want.index, want.last,
                              rsp_ch.slot_value, rsp_ch.slot_bin, rsp_ch.slot_index,
                              rsp_ch.last_slot);
               end
            end
         end
         if (hold_left == 0 && hold_start) begin
            hold_start = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // one register write per cycle; caller lowers csr_we when done
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_START0:    win_start[0] = data;
         CSR_START1:    win_start[1] = data;
         CSR_BIN_WIDTH: bin_w = data[BWID_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_window(logic [31:0] s0, logic [31:0] s1, logic [31:0] w);
      write_reg(CSR_START0, s0);
      write_reg(CSR_START1, s1);
      write_reg(CSR_BIN_WIDTH, w);
      write_reg(CSR_SPARE, $urandom);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // let the block drain completely before touching registers
   task automatic drain();
      while (pending_slots.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // offer one transaction, return at the edge where it is taken
   task automatic send_event(event_row_type r);
      slot_type predicted [$];
      if ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= r.mode;
      req_ch.batch      <= r.batch;
      req_ch.pixel_x    <= r.px;
      req_ch.pixel_y    <= r.py;
      req_ch.polarity   <= r.pol;
      req_ch.bin_index  <= r.bin;
      req_ch.event_time <= r.t;
      do @(posedge clock); while (!req_ch.ready);
      bin_queue_step(r, predicted);
      if (r.typed) begin
         for (int k = 0; k < QLEN; k++) begin
            predicted[k].value = (k == QLEN - 1) ? r.newest_val : '0;
            predicted[k].bin   = (k == QLEN - 1) ? r.newest_bin : NO_BIN;
         end
      end
      foreach (predicted[k]) pending_slots.push_back(predicted[k]);
   endtask

   // hot cells see sequences of rising bins so histories fill and wrap
   event_row_type hot [6];
   int            hot_bin [6];

   function automatic event_row_type random_event();
      event_row_type r;
      int     h, roll;
      longint w, off;
      h = $urandom_range(5);
      r = hot[h];
      r.typed = 1'b0;
      roll = $urandom_range(99);
      if (roll < 10) begin
         r.batch = 1'($urandom); r.px = PIX_W'($urandom); r.py = PIX_W'($urandom);
         r.pol = 1'($urandom);
      end
      r.mode = ($urandom_range(7) == 0) ? MODE_READ : MODE_ACC;
      roll = $urandom_range(99);
      if (roll < 40 && hot_bin[h] < 4095) hot_bin[h]++;
      if (roll < 75)      r.bin = IDX_W'(hot_bin[h]);
      else if (roll < 88) r.bin = (hot_bin[h] > 0) ?
                                  IDX_W'(hot_bin[h] - int'($urandom_range(1, 2))) : '0;
      else                r.bin = IDX_W'($urandom);
      w = (bin_w == 0) ? 1 : longint'(bin_w);
      if ($urandom_range(99) < 85) off = longint'($urandom_range(0, 999)) * w / 1000;
      else                         off = longint'($urandom_range(0, 2999)) * w / 1000 - w;
      r.t = 32'(longint'(win_start[r.batch]) + w * longint'(r.bin) + off);
      if ($urandom_range(99) < 8) r.t = $urandom;
      return r;
   endfunction

   task automatic random_phase(idle_mode_type m, int count, bit squeeze);
      case (m)
         IDLE_SEND_LIGHT: begin send_idle = 25; recv_idle = 58; end
         IDLE_RECV_LIGHT: begin send_idle = 58; recv_idle = 25; end
         default:         begin send_idle = 0;  recv_idle = 0;  end
      endcase
      if (squeeze) hold_start = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (squeeze && i < 6) send_event('{MODE_READ, hot[i].batch, hot[i].px, hot[i].py,
                                            hot[i].pol, 12'd0, 32'd0, 1'b0, 24'sd0, -13'sd1});
         else send_event(random_event());
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      drain();   // sender waits here for every outstanding slot
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_ACC;
      req_ch.batch <= 1'b0;
      req_ch.pixel_x <= '0;
      req_ch.pixel_y <= '0;
      req_ch.polarity <= 1'b0;
      req_ch.bin_index <= '0;
      req_ch.event_time <= '0;
      win_start[0] = '0;
      win_start[1] = '0;
      bin_w = BIN_WIDTH_RESET;
      for (int c = 0; c < CELLS; c++) begin
         open_val[c] = '0;
         open_bin[c] = NO_BIN;
         hist_head[c] = 0;
         hist_cnt[c] = 0;
      end
      foreach (hot[i]) begin
         hot[i].batch = 1'($urandom); hot[i].px = PIX_W'($urandom);
         hot[i].py = PIX_W'($urandom); hot[i].pol = 1'($urandom);
         hot_bin[i] = $urandom_range(0, 60);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass at reset register values; ready stays low through the clearing pass
      send_idle = 0;
      recv_idle = 0;
      foreach (directed_rows[i]) send_event(directed_rows[i]);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      drain();

      // zero width acts as one, batch 1 window at the top of the time range
      program_window(32'd0, 32'hFFFFFFFF, 32'd0);
      random_phase(IDLE_SEND_LIGHT, 80, 1'b0);
      // widest bins, random windows
      program_window($urandom, $urandom, 32'h00FFFFFF);
      random_phase(IDLE_RECV_LIGHT, 80, 1'b0);
      // ordinary widths, long receiver hold with readouts queued behind it
      program_window($urandom, $urandom, $urandom_range(1, 5000));
      random_phase(IDLE_NONE, 80, 1'b1);

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
